// ----- rtl/rfpg_pkg.sv -----
// ---------------------------------------------------------------------------
// rfpg_pkg: shared types and constants of the rectangle frame pixel generator
// Widths, register indexes, opcodes and the state/config/result structs.
// ---------------------------------------------------------------------------
package rfpg_pkg;

    localparam int COORD_BITS   = 12;
    localparam int THICK_BITS   = 8;
    localparam int COLOR_BITS   = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = COLOR_BITS;

    // compare width that holds coordinate + thickness without overflow
    localparam int SUM_BITS =
        ((COORD_BITS > THICK_BITS) ? COORD_BITS : THICK_BITS) + 1;

    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ANCHOR_X   = 2'd0,
        CFG_ANCHOR_Y   = 2'd1,
        CFG_THICKNESS  = 2'd2,
        CFG_DRAW_COLOR = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] anchor_x;
        logic [COORD_BITS-1:0] anchor_y;
        logic [THICK_BITS-1:0] thickness;
        logic [COLOR_BITS-1:0] draw_color;
    } t_cfg;

    typedef struct packed {
        logic                  active;
        logic                  step_x_neg;
        logic                  step_y_neg;
        logic [COORD_BITS-1:0] span_x;
        logic [COORD_BITS-1:0] span_y;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } t_frame;

    typedef struct packed {
        logic                  pixel_valid;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } t_result;

endpackage

// ----- rtl/rfpg_step.sv -----
// ---------------------------------------------------------------------------
// rfpg_step: one-item frame step
// Combinational next frame state and result for one start or next item.
// ---------------------------------------------------------------------------
module rfpg_step
    import rfpg_pkg::*;
(
    input  t_frame                i_frame,
    input  t_cfg                  i_cfg,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_corner_x,
    input  logic [COORD_BITS-1:0] i_corner_y,
    output t_frame                o_frame,
    output t_result               o_result
);

    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] start_span_x;
    logic [COORD_BITS-1:0] start_span_y;
    logic [COORD_BITS-1:0] col_inc;
    logic [SUM_BITS-1:0]   e_row;
    logic [SUM_BITS-1:0]   e_col;
    logic [SUM_BITS-1:0]   e_span_x;
    logic [SUM_BITS-1:0]   e_span_y;
    logic [SUM_BITS-1:0]   e_thick;
    logic [SUM_BITS-1:0]   jump_col;
    logic                  thick_zero;
    logic                  col_wrap;
    logic                  interior;
    logic                  row_more;

    always_comb begin
        neg_x        = !(i_corner_x > i_cfg.anchor_x);
        neg_y        = !(i_corner_y > i_cfg.anchor_y);
        start_span_x = neg_x ? (i_cfg.anchor_x - i_corner_x) : (i_corner_x - i_cfg.anchor_x);
        start_span_y = neg_y ? (i_cfg.anchor_y - i_corner_y) : (i_corner_y - i_cfg.anchor_y);

        col_inc    = i_frame.col + 1'b1;
        e_row      = SUM_BITS'(i_frame.row);
        e_col      = SUM_BITS'(col_inc);
        e_span_x   = SUM_BITS'(i_frame.span_x);
        e_span_y   = SUM_BITS'(i_frame.span_y);
        e_thick    = SUM_BITS'(i_cfg.thickness);
        thick_zero = (i_cfg.thickness == '0);
        col_wrap   = (col_inc >= i_frame.span_x);
        interior   = (e_row >= e_thick) && ((e_row + e_thick) <= e_span_y) &&
                     (e_col >= e_thick) && ((e_col + e_thick) <= e_span_x);
        jump_col   = e_span_x - e_thick + SUM_BITS'(1);
        row_more   = ((e_row + SUM_BITS'(1)) < e_span_y);
    end

    always_comb begin
        o_frame  = i_frame;
        o_result = '0;
        if (i_op == OP_START) begin
            o_frame.step_x_neg = neg_x;
            o_frame.step_y_neg = neg_y;
            o_frame.span_x     = start_span_x;
            o_frame.span_y     = start_span_y;
            o_frame.row        = '0;
            o_frame.col        = '0;
            // the corner pixel is never interior once thickness is nonzero
            o_frame.active     = (start_span_x != '0) && (start_span_y != '0) && !thick_zero;
            o_result.last_pixel = !o_frame.active;
        end else if (!i_frame.active) begin
            o_result.last_pixel = 1'b1;
        end else begin
            o_result.pixel_valid = 1'b1;
            o_result.pixel_x = i_frame.step_x_neg ? (i_cfg.anchor_x - i_frame.col)
                                                  : (i_cfg.anchor_x + i_frame.col);
            o_result.pixel_y = i_frame.step_y_neg ? (i_cfg.anchor_y - i_frame.row)
                                                  : (i_cfg.anchor_y + i_frame.row);
            o_result.pixel_color = i_cfg.draw_color;

            // each item takes at most one interior jump or one row wrap, never both
            if (thick_zero) begin
                o_frame.active = 1'b0;
            end else if (col_wrap || (interior && (i_cfg.thickness == THICK_BITS'(1)))) begin
                o_frame.row    = i_frame.row + 1'b1;
                o_frame.col    = '0;
                o_frame.active = row_more;
            end else if (interior) begin
                o_frame.col = jump_col[COORD_BITS-1:0];
            end else begin
                o_frame.col = col_inc;
            end
            o_result.last_pixel = !o_frame.active;
        end
    end

endmodule

// ----- rtl/rectangle_frame_pixel_generator_core.sv -----
// ---------------------------------------------------------------------------
// rectangle_frame_pixel_generator_core: rectangle frame pixel generator
// Scans the border pixels of a rectangle between a fixed anchor and a
// dragged corner, one result item per input item.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid / tready        tuser = op, tdata = corner_x, corner_y
//   m_axis    out  tvalid / tready        tuser = pixel_valid, tlast = last_pixel,
//                                         tdata = pixel_x, pixel_y, pixel_color
//   cfg       in   i_cfg_we (no wait)     i_cfg_idx, i_cfg_wdata
//
// One item per cycle while the skid register is empty: the frame step is a single
// combinational pass from the frame state register into the output register.
// A skid register behind the output takes one item during an m_axis stall;
// s_axis_tready drops only while the skid register is full.
// Reset (synchronous, active low) leaves the frame idle and both output
// registers empty; thickness resets to 1, the other registers to 0.
// ---------------------------------------------------------------------------
module rectangle_frame_pixel_generator_core
    import rfpg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // input items
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // corner_x, corner_y
    input  logic                     s_axis_tuser,  // op
    // result items
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color
    output logic                     m_axis_tuser,  // pixel_valid
    output logic                     m_axis_tlast   // last_pixel
);

    t_cfg    r_cfg;
    t_frame  r_frame;
    t_frame  n_frame;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_accept;
    logic    out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.anchor_x   <= '0;
            r_cfg.anchor_y   <= '0;
            r_cfg.thickness  <= THICK_BITS'(1);
            r_cfg.draw_color <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ANCHOR_X:   r_cfg.anchor_x   <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_ANCHOR_Y:   r_cfg.anchor_y   <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_THICKNESS:  r_cfg.thickness  <= i_cfg_wdata[THICK_BITS-1:0];
                CFG_DRAW_COLOR: r_cfg.draw_color <= i_cfg_wdata[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    rfpg_step u_step (
        .i_frame    (r_frame),
        .i_cfg      (r_cfg),
        .i_op       (s_axis_tuser),
        .i_corner_x (s_axis_tdata[COORD_BITS-1:0]),
        .i_corner_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .o_frame    (n_frame),
        .o_result   (n_result)
    );

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (in_accept) begin
            r_frame <= n_frame;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            // drain the skid item first; a new item cannot arrive then
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.pixel_valid;
    assign m_axis_tlast  = r_out.last_pixel;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_out.pixel_color, r_out.pixel_y, r_out.pixel_x});

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_active_spans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame.active |-> (r_frame.span_x != '0) && (r_frame.span_y != '0))
        else $error("frame active with an empty span");

    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame.active |-> (r_frame.col < r_frame.span_x) && (r_frame.row < r_frame.span_y))
        else $error("frame position outside the rectangle");

    a_stall_holds_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("skid item lost during output stall");

endmodule
